// ----- src/irt_pkg.sv -----
// irt_pkg: shared types and constants of the inode reference table
// item structs, status and command codes, register indexes, sequencer states
// no dependencies
package irt_pkg;

  localparam int unsigned DEV_W   = 8;
  localparam int unsigned CLUS_W  = 28;
  localparam int unsigned OFF_W   = 22;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned REF_W   = 16;
  localparam int unsigned KEY_W   = 44;
  localparam int unsigned CB_W    = 17;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned PROD_W  = CLUS_W + CB_W;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 28;
  localparam int unsigned DIV_CNT_W = $clog2(OFF_W + 1);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_MISMATCH = 3'd2;
  localparam logic [STAT_W-1:0] STAT_PUT_FREE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd4;

  localparam logic [CFG_A_W-1:0] CFG_CLUSTER_BYTES = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_ROOT_START    = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_FAT32_MODE    = 2'd2;

  localparam logic [CB_W-1:0]   CLUSTER_BYTES_RST = 17'd4096;
  localparam logic [CLUS_W-1:0] ROOT_START_RST    = 28'd2;
  localparam logic              FAT32_MODE_RST    = 1'b1;

  localparam logic [REF_W-1:0] REF_MAX = 16'hFFFF;

  typedef struct packed {
    logic              cmd;
    logic [DEV_W-1:0]  device;
    logic [CLUS_W-1:0] dir_cluster;
    logic [OFF_W-1:0]  dir_offset;
    logic [SLOT_W-1:0] release_slot;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [REF_W-1:0]  ref_count;
    logic [KEY_W-1:0]  entry_number;
    logic              fresh;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [REF_W-1:0]  refs;
    logic [DEV_W-1:0]  device;
    logic [KEY_W-1:0]  key;
    logic [CLUS_W-1:0] cluster;
    logic [OFF_W-1:0]  offset;
  } rec_t;

  typedef struct packed {
    logic             start;
    logic [OFF_W-1:0] dividend;
    logic [CB_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             busy;
    logic [OFF_W-1:0] remainder;
  } rem_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SCAN,
    S_PUT_RD,
    S_PUT_EV,
    S_DONE
  } irt_state_e;

endpackage

// ----- src/irt_rem_unit.sv -----
// irt_rem_unit: restoring remainder unit, one dividend bit per cycle
// a zero divisor passes the dividend through unchanged
// depends on irt_pkg
module irt_rem_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irt_pkg::rem_req_t req_i,
  output irt_pkg::rem_rsp_t rsp_o
);
  import irt_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [OFF_W-1:0]     dvd_q, dvd_d;
  logic [OFF_W-1:0]     rem_q, rem_d;
  logic [CB_W-1:0]      div_q, div_d;
  logic [CB_W:0]        shifted;
  logic [CB_W:0]        step_val;

  always_comb begin
    shifted  = {rem_q[CB_W-1:0], dvd_q[OFF_W-1]};
    step_val = (shifted >= {1'b0, div_q}) ? shifted - {1'b0, div_q} : shifted;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      div_d = req_i.divisor;
      if (req_i.divisor == '0) begin
        rem_d = req_i.dividend;
      end else begin
        busy_d = 1'b1;
        cnt_d  = DIV_CNT_W'(OFF_W);
        dvd_d  = req_i.dividend;
        rem_d  = '0;
      end
    end else if (busy_q) begin
      rem_d = OFF_W'(step_val);
      dvd_d = {dvd_q[OFF_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.remainder = rem_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("remainder unit restarted while busy");
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("remainder unit busy with empty count");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == DIV_CNT_W'(1)) |=> !busy_q)
    else $error("remainder unit overran its step count");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> rem_q < OFF_W'(div_q)) else $error("remainder not below divisor");
`endif

endmodule

// ----- src/inode_ref_table_top.sv -----
// inode_ref_table_top: reference-counted directory-entry handle table
// get item: passes through the multiply, the bit-serial remainder unit and a scan of the
//   slot memory that reads one entry per cycle, then waits in the done state for the output
// put item: one read and, for a live slot in range, one write of the slot memory
// one item at a time; async active-low reset empties the table and loads register defaults
module inode_ref_table_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  irt_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output irt_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_we_i,
  input  logic [irt_pkg::CFG_A_W-1:0]        cfg_addr_i,
  input  logic [irt_pkg::CFG_D_W-1:0]        cfg_wdata_i
);
  import irt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  irt_state_e state_q, state_d;

  logic [CB_W-1:0]   cb_q;
  logic [CLUS_W-1:0] root_q;
  logic              fat_q;

  in_item_t          item_q;
  logic [CLUS_W-1:0] clus_q;
  logic [PROD_W-1:0] prod_q;
  logic [KEY_W-1:0]  key_q;

  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              ev_q, ev_d;
  logic [IDX_W-1:0]  ev_idx_q, ev_idx_d;
  logic              free_found_q, free_found_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;

  out_item_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q;

  rec_t                   slot_mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  rec_t                   rd_q;
  logic                   rd_vld_q;
  logic                   mem_re, mem_we;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  rec_t                   wr_rec;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  logic accept, out_load;
  logic rd_live, ev_match, ev_last, claim_now, full_now, put_ok, put_in_range;
  logic ref_sat, rec_differs;
  logic [IDX_W-1:0] claim_idx;
  logic [REF_W-1:0] ref_inc;

  irt_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign rem_req.start    = accept && (in_item_i.cmd == CMD_GET);
  assign rem_req.dividend = in_item_i.dir_offset;
  assign rem_req.divisor  = cb_q;

  // evaluation of the entry read in the previous cycle
  always_comb begin
    rd_live      = rd_vld_q && (rd_q.refs != '0);
    ev_match     = ev_q && rd_live && (rd_q.device == item_q.device) && (rd_q.key == key_q);
    ev_last      = ev_q && (ev_idx_q == IDX_W'(TABLE_ENTRIES - 1));
    claim_now    = ev_last && !ev_match && (free_found_q || !rd_live);
    full_now     = ev_last && !ev_match && free_found_q == 1'b0 && rd_live;
    claim_idx    = free_found_q ? free_idx_q : ev_idx_q;
    put_in_range = 32'(item_q.release_slot) < TABLE_ENTRIES;
    put_ok       = put_in_range && rd_live;
    ref_sat      = rd_q.refs == REF_MAX;
    ref_inc      = ref_sat ? rd_q.refs : rd_q.refs + 1'b1;
    rec_differs  = (rd_q.cluster != clus_q) || (rd_q.offset != item_q.dir_offset);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_item_i.cmd == CMD_PUT) ? S_PUT_RD : S_MUL;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (!rem_rsp.busy) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ev_match || claim_now || full_now) begin
          state_d = S_DONE;
        end
      end
      S_PUT_RD: state_d = S_PUT_EV;
      S_PUT_EV: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    mem_re       = 1'b0;
    rd_addr      = issue_q[IDX_W-1:0];
    mem_we       = 1'b0;
    wr_addr      = ev_idx_q;
    wr_rec       = rd_q;
    issue_d      = issue_q;
    ev_d         = 1'b0;
    ev_idx_d     = ev_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_d        = res_q;
    case (state_q)
      S_DIV: begin
        issue_d      = '0;
        free_found_d = 1'b0;
      end
      S_SCAN: begin
        mem_re   = issue_q < CNT_W'(TABLE_ENTRIES);
        issue_d  = mem_re ? issue_q + 1'b1 : issue_q;
        ev_d     = mem_re;
        ev_idx_d = rd_addr;
        if (ev_q && !rd_live && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = ev_idx_q;
        end
        res_d.entry_number = key_q;
        res_d.fresh        = 1'b0;
        if (ev_match) begin
          mem_we          = 1'b1;
          wr_rec.refs     = ref_inc;
          res_d.slot      = SLOT_W'(ev_idx_q);
          res_d.ref_count = ref_inc;
          res_d.status    = rec_differs ? STAT_MISMATCH : (ref_sat ? STAT_OVERFLOW : STAT_OK);
        end else if (claim_now) begin
          mem_we          = 1'b1;
          wr_addr         = claim_idx;
          wr_rec.refs     = REF_W'(1);
          wr_rec.device   = item_q.device;
          wr_rec.key      = key_q;
          wr_rec.cluster  = clus_q;
          wr_rec.offset   = item_q.dir_offset;
          res_d.slot      = SLOT_W'(claim_idx);
          res_d.ref_count = REF_W'(1);
          res_d.fresh     = 1'b1;
          res_d.status    = STAT_OK;
        end else begin
          res_d.slot      = '0;
          res_d.ref_count = '0;
          res_d.status    = STAT_FULL;
        end
      end
      S_PUT_RD: begin
        mem_re  = 1'b1;
        rd_addr = IDX_W'(item_q.release_slot);
      end
      S_PUT_EV: begin
        wr_addr     = IDX_W'(item_q.release_slot);
        wr_rec.refs = rd_q.refs - 1'b1;
        res_d.slot  = item_q.release_slot;
        res_d.fresh = 1'b0;
        if (put_ok) begin
          mem_we             = 1'b1;
          res_d.ref_count    = wr_rec.refs;
          res_d.entry_number = rd_q.key;
          res_d.status       = STAT_OK;
        end else begin
          res_d.ref_count    = '0;
          res_d.entry_number = '0;
          res_d.status       = STAT_PUT_FREE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      ev_q         <= 1'b0;
      free_found_q <= 1'b0;
      issue_q      <= '0;
      valid_q      <= '0;
      cb_q         <= CLUSTER_BYTES_RST;
      root_q       <= ROOT_START_RST;
      fat_q        <= FAT32_MODE_RST;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      ev_q         <= ev_d;
      free_found_q <= free_found_d;
      issue_q      <= issue_d;
      if (mem_we) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_CLUSTER_BYTES: cb_q   <= cfg_wdata_i[CB_W-1:0];
          CFG_ROOT_START:    root_q <= cfg_wdata_i[CLUS_W-1:0];
          CFG_FAT32_MODE:    fat_q  <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      clus_q <= (in_item_i.dir_cluster == '0 && fat_q) ? root_q : in_item_i.dir_cluster;
    end
    prod_q <= clus_q * cb_q;
    if (state_q == S_DIV && !rem_rsp.busy) begin
      key_q <= KEY_W'(prod_q + PROD_W'(rem_rsp.remainder));
    end
    ev_idx_q   <= ev_idx_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
    if (out_load) begin
      out_item_q <= res_q;
    end
  end

  // slot memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[wr_addr] <= wr_rec;
    end
    if (mem_re) begin
      rd_q     <= slot_mem_q[rd_addr];
      rd_vld_q <= valid_q[rd_addr];
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_SCAN || state_q == S_PUT_EV))
    else $error("slot memory written outside scan or put");
  a_put_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_PUT_EV) |-> rd_q.refs != '0)
    else $error("release would underflow a reference count");
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside done state");
  a_idle_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !rem_rsp.busy)
    else $error("remainder unit busy while idle");
  a_accept_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted item left no work");
`endif

endmodule
